/* rtl/core/tvf_pkg.sv */
// ----------------------------------------------------------------------------
// Text stream visualize filter package
// Item types, register indexes and character codes shared by the filter.
// ----------------------------------------------------------------------------
package tvf_pkg;

    // One text byte in, with its start-of-file marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_item;

    // One shown character out; last_of_run closes the burst for an input item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    localparam int CFG_ADDR_W = 3;
    localparam int COUNT_W    = 20;
    localparam int MAX_OUT    = 11;
    localparam int OUT_CNT_W  = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUMBER_ALL       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SQUEEZE_BLANK    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_META   = 8'd128;
    localparam logic [7:0] CH_HIGH   = 8'd160;
    localparam logic [7:0] CH_CTL_END = 8'd32;
    localparam logic [7:0] CARET_OFS = 8'd64;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

endpackage

/* rtl/core/text_stream_visualize_filter.sv */
// The first character of an item appears in the cycle after the item is accepted.
// One input item per cycle while every item shows as one character and the output is
// ready; a longer item holds the input until its last character leaves the single output.
// A squeezed empty line is taken and produces no output.
// Reset (synchronous, active low) clears the options, the line counter and the burst.
// ----------------------------------------------------------------------------
// Text stream visualize filter
// Turns a text byte stream into its shown form: line numbers, end marks, tab and
// control-byte notation, and squeezing of repeated empty lines.
// ----------------------------------------------------------------------------
module text_stream_visualize_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration writes.
    input  logic                          i_cfg_we,
    input  logic [tvf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic                          i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tvf_pkg::t_in_item             i_in_item,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tvf_pkg::t_out_item            o_out_item
);
    import tvf_pkg::*;

    // A line number takes NUMBER_DIGITS places and a tab; the padding of an
    // empty line under number_nonblank with show_ends is just as long.
    localparam int HEAD_LEN = NUMBER_DIGITS + 1;

    // The counter stops at the largest number that fits in the field, and
    // never goes past what the 20-bit counter holds.
    function automatic logic [COUNT_W-1:0] count_limit(input int digits);
        logic [63:0] lim;
        lim = 64'd1;
        for (int i = 0; i < digits; i++) begin
            lim = lim * 64'd10;
            if (lim > (64'd1 << COUNT_W)) begin
                return {COUNT_W{1'b1}};
            end
        end
        return COUNT_W'(lim - 64'd1);
    endfunction

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = count_limit(NUMBER_DIGITS);

    // Option registers.
    logic r_nb, r_na, r_se, r_sq, r_st, r_snp;

    // Line state. The count is kept both in binary, for the limit check,
    // and in decimal digits, which is what gets shown. Digit 0 is the most
    // significant one.
    logic [COUNT_W-1:0] r_count, n_count;
    logic [3:0]         r_bcd [NUMBER_DIGITS];
    logic [3:0]         n_bcd [NUMBER_DIGITS];
    logic [7:0]         r_prev, n_prev;
    logic [1:0]         r_empty, n_empty;

    // Burst register: the characters of one item, shifted out from entry 0.
    logic [7:0]           r_buf [MAX_OUT];
    logic [7:0]           n_buf [MAX_OUT];
    logic [OUT_CNT_W-1:0] r_cnt, n_cnt;
    logic [OUT_CNT_W-1:0] n_len;

    logic w_fire_in, w_fire_out;

    // Ready is high whenever the burst register is empty or about to give
    // up its last character, so a new item enters in the same cycle as the
    // previous burst ends.
    assign o_in_ready  = (r_cnt == '0) || ((r_cnt == OUT_CNT_W'(1)) && i_out_ready);
    assign o_out_valid = (r_cnt != '0);
    assign w_fire_in   = i_in_valid && o_in_ready;
    assign w_fire_out  = o_out_valid && i_out_ready;

    assign o_out_item.out_byte    = r_buf[0];
    assign o_out_item.last_of_run = (r_cnt == OUT_CNT_W'(1));

    // Configuration writes. Indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb  <= 1'b0;
            r_na  <= 1'b0;
            r_se  <= 1'b0;
            r_sq  <= 1'b0;
            r_st  <= 1'b0;
            r_snp <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_NUMBER_NONBLANK:  r_nb  <= i_cfg_wdata;
                CFG_NUMBER_ALL:       r_na  <= i_cfg_wdata;
                CFG_SHOW_ENDS:        r_se  <= i_cfg_wdata;
                CFG_SQUEEZE_BLANK:    r_sq  <= i_cfg_wdata;
                CFG_SHOW_TABS:        r_st  <= i_cfg_wdata;
                CFG_SHOW_NONPRINTING: r_snp <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole item is worked out here in one pass, from the input payload
    // and the line state, into the next burst and the next line state.
    always_comb begin
        logic [7:0]         c, c2;
        logic               sof, prev_nl, is_nl, blank_run, drop;
        logic               do_num, do_pad, has_head, step_count, carry, lead;
        logic [7:0]         base_prev;
        logic [COUNT_W-1:0] base_count;
        logic [1:0]         base_empty, er_inc;
        logic [3:0]         base_bcd [NUMBER_DIGITS];
        logic [3:0]         inc_bcd  [NUMBER_DIGITS];
        logic [3:0]         disp_bcd [NUMBER_DIGITS];
        logic [7:0]         head_byte [MAX_OUT];
        logic [7:0]         mid_byte [4];
        logic [7:0]         tail_byte [2];
        logic [1:0]         mc;
        logic [1:0]         tc;
        logic [4:0]         ofs, rel, t_rel, total;

        c   = i_in_item.data_byte;
        sof = i_in_item.start_of_file;

        // A start-of-file marker restarts the line state before this byte.
        base_prev  = sof ? CH_NL : r_prev;
        base_count = sof ? '0 : r_count;
        base_empty = sof ? 2'd0 : r_empty;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            base_bcd[i] = sof ? 4'd0 : r_bcd[i];
        end

        prev_nl = (base_prev == CH_NL);
        is_nl   = (c == CH_NL);

        // Squeezing: the first empty line after a line end passes, any
        // further one is swallowed whole.
        blank_run = r_sq && is_nl && prev_nl;
        er_inc    = (base_empty == 2'd3) ? 2'd3 : base_empty + 2'd1;
        drop      = blank_run && (er_inc > 2'd1);
        n_empty   = blank_run ? er_inc : 2'd0;

        // Line number ahead of the first byte of a line; number_nonblank
        // wins over number_all.
        do_num     = !drop && prev_nl && ((r_nb && !is_nl) || (r_na && !r_nb));
        step_count = do_num && (base_count < COUNT_LIMIT);
        do_pad     = r_se && r_nb && is_nl && prev_nl;
        has_head   = do_num || do_pad;

        // Decimal increment, least significant digit first.
        carry = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            if (carry && (base_bcd[i] == 4'd9)) begin
                inc_bcd[i] = 4'd0;
            end else if (carry) begin
                inc_bcd[i] = base_bcd[i] + 4'd1;
                carry      = 1'b0;
            end else begin
                inc_bcd[i] = base_bcd[i];
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            disp_bcd[i] = step_count ? inc_bcd[i] : base_bcd[i];
            n_bcd[i]    = disp_bcd[i];
        end
        n_count = step_count ? base_count + COUNT_W'(1) : base_count;

        // Head: right-justified number or blank padding, then a tab.
        // Leading zeros show as spaces, but the last digit always shows.
        for (int k = 0; k < MAX_OUT; k++) begin
            head_byte[k] = CH_TAB;
        end
        lead = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (do_pad || (lead && (disp_bcd[i] == 4'd0) && (i != NUMBER_DIGITS - 1))) begin
                head_byte[i] = CH_SPACE;
            end else begin
                lead         = 1'b0;
                head_byte[i] = {ASCII_DIGIT_HI, disp_bcd[i]};
            end
        end

        // Middle: an end mark before a newline, or the prefix of a control
        // byte, which also moves the byte into the printable range.
        c2          = c;
        mc          = 2'd0;
        mid_byte[0] = CH_CARET;
        mid_byte[1] = CH_DASH;
        mid_byte[2] = CH_CARET;
        mid_byte[3] = CH_CARET;
        if (r_se && is_nl) begin
            mc          = 2'd1;
            mid_byte[0] = CH_DOLLAR;
        end else if (r_snp) begin
            if ((c >= CH_META) && (c < CH_HIGH)) begin
                mc          = 2'd3;
                mid_byte[0] = CH_M;
                c2          = c - CARET_OFS;
            end else if (c == CH_DEL) begin
                mc = 2'd1;
                c2 = CH_QMARK;
            end else if ((c < CH_CTL_END) && !is_nl && (c != CH_TAB)) begin
                mc = 2'd1;
                c2 = c + CARET_OFS;
            end
        end

        // Tail: the byte itself, or a tab as caret and I.
        if (r_st && (c2 == CH_TAB)) begin
            tc           = 2'd2;
            tail_byte[0] = CH_CARET;
            tail_byte[1] = CH_I;
        end else begin
            tc           = 2'd1;
            tail_byte[0] = c2;
            tail_byte[1] = c2;
        end
        n_prev = c2;

        // Lay the three parts out into the burst; anything past the last
        // entry is dropped.
        ofs = has_head ? 5'(HEAD_LEN) : 5'd0;
        for (int k = 0; k < MAX_OUT; k++) begin
            rel   = 5'(k) - ofs;
            t_rel = rel - {3'b000, mc};
            if (5'(k) < ofs) begin
                n_buf[k] = head_byte[k];
            end else if (rel < {3'b000, mc}) begin
                n_buf[k] = mid_byte[rel[1:0]];
            end else begin
                n_buf[k] = tail_byte[t_rel[0]];
            end
        end
        total = ofs + {3'b000, mc} + {3'b000, tc};
        if (drop) begin
            n_len = '0;
        end else if (total > 5'(MAX_OUT)) begin
            n_len = OUT_CNT_W'(MAX_OUT);
        end else begin
            n_len = total[OUT_CNT_W-1:0];
        end
    end

    // Burst count: loaded when an item enters, counted down as characters
    // leave. An item enters only when the old burst is gone or ending.
    always_comb begin
        if (w_fire_in) begin
            n_cnt = n_len;
        end else if (w_fire_out) begin
            n_cnt = r_cnt - OUT_CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_count <= '0;
            r_prev  <= CH_NL;
            r_empty <= 2'd0;
            for (int i = 0; i < NUMBER_DIGITS; i++) begin
                r_bcd[i] <= 4'd0;
            end
        end else begin
            r_cnt <= n_cnt;
            if (w_fire_in) begin
                r_count <= n_count;
                r_prev  <= n_prev;
                r_empty <= n_empty;
                for (int i = 0; i < NUMBER_DIGITS; i++) begin
                    r_bcd[i] <= n_bcd[i];
                end
            end
        end
    end

    // Burst data needs no reset; it is only read while the count is nonzero.
    always_ff @(posedge i_clk) begin
        if (w_fire_in) begin
            for (int k = 0; k < MAX_OUT; k++) begin
                r_buf[k] <= n_buf[k];
            end
        end else if (w_fire_out) begin
            for (int k = 0; k < MAX_OUT - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

endmodule

/* test/text_stream_visualize_filter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text stream visualize filter testbench
// Drives text bytes through the filter under many option settings and checks
// every shown character, and its end-of-burst flag, against a line-state
// predictor kept inside the bench. A short directed table comes first, then
// random text phases.
// ----------------------------------------------------------------------------
module text_stream_visualize_filter_test;

    import tvf_pkg::*;

    localparam int DIGITS = 6;

    // Register indexes beyond the option list; a write there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [7:0] CH_ZERO = 8'h30;

    // Directed table rows: either an option write or one text item.
    typedef enum logic {
        ROW_OPTION,
        ROW_TEXT
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic                  val;
        logic [7:0]            data;
        logic                  sof;
        logic                  typed;     // shown characters given in the row itself
        logic [3:0]            n_shown;
        logic [8*MAX_OUT-1:0]  shown_text;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic                  i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;

    // Options and line state as the predictor sees them.
    logic               opt_number_nonblank;
    logic               opt_number_all;
    logic               opt_show_ends;
    logic               opt_squeeze;
    logic               opt_show_tabs;
    logic               opt_nonprinting;
    logic [COUNT_W-1:0] line_cnt;
    logic [7:0]         last_shown;
    logic [1:0]         blank_run;

    t_out_item burst[$];      // characters predicted for the current item
    t_out_item shown_q[$];    // characters still owed by the filter
    t_row      plan[$];

    // Shared controls between the sender and the receiver.
    logic hold_req = 1'b0;    // asks the receiver for one long hold-off
    logic steady = 1'b0;      // neither side idles while this is set

    int bad_count = 0;
    int chars_in = 0;
    int chars_out = 0;
    int option_sets = 0;

    text_stream_visualize_filter #(
        .NUMBER_DIGITS(DIGITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run must be over long before this; a hang anywhere lands here.
    initial begin
        #3_000_000;
        $display("Timed out with %0d characters still owed", shown_q.size());
        $display("FAIL text_stream_visualize_filter");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Highest line number: all nines in the number field, never past the
    // counter width. At six places this sits far beyond any run here.
    function automatic logic [COUNT_W-1:0] count_ceiling();
        longint lim;
        lim = 1;
        for (int i = 0; i < DIGITS; i++) begin
            lim = lim * 10;
            if (lim > (longint'(1) << COUNT_W)) begin
                return {COUNT_W{1'b1}};
            end
        end
        return COUNT_W'(lim - 1);
    endfunction

    // The filter has one output burst of at most MAX_OUT characters per item.
    function automatic void put_char(input logic [7:0] c);
        if (burst.size() < MAX_OUT) begin
            burst.push_back({c, 1'b0});
        end
    endfunction

    // Right-justified number, leading zeros shown as spaces, then a tab.
    function automatic void put_line_number(input logic [COUNT_W-1:0] v);
        int unsigned rest;
        int          digs[DIGITS];
        logic        lead;
        rest = v;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            digs[i] = rest % 10;
            rest = rest / 10;
        end
        lead = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (lead && digs[i] == 0 && i != DIGITS - 1) begin
                put_char(CH_SPACE);
            end else begin
                lead = 1'b0;
                put_char(CH_ZERO + 8'(digs[i]));
            end
        end
        put_char(CH_TAB);
    endfunction

    // Works out the shown characters of one text byte into burst and moves
    // the line state on.
    function automatic void predict_shown(input logic [7:0] b, input logic sof);
        logic [7:0] c;
        logic       at_line_start;
        logic       number_every;
        t_out_item  tail;
        c = b;
        burst.delete();
        number_every = opt_number_all && !opt_number_nonblank;
        if (sof) begin
            line_cnt = '0;
            last_shown = CH_NL;
            blank_run = '0;
        end
        at_line_start = (last_shown == CH_NL);

        // A second empty line in a row is swallowed whole while squeezing.
        if (opt_squeeze && c == CH_NL && at_line_start) begin
            if (blank_run < 2'd3) begin
                blank_run = blank_run + 2'd1;
            end
            if (blank_run > 2'd1) begin
                return;
            end
        end else begin
            blank_run = '0;
        end

        if (at_line_start && ((opt_number_nonblank && c != CH_NL) || number_every)) begin
            if (line_cnt < count_ceiling()) begin
                line_cnt = line_cnt + 1'b1;
            end
            put_line_number(line_cnt);
        end

        if (opt_show_ends) begin
            // An unnumbered empty line still gets a blank number field.
            if (opt_number_nonblank && c == CH_NL && at_line_start) begin
                for (int i = 0; i < DIGITS; i++) begin
                    put_char(CH_SPACE);
                end
                put_char(CH_TAB);
            end
            if (c == CH_NL) begin
                put_char(CH_DOLLAR);
            end
        end

        if (opt_nonprinting) begin
            if (c >= CH_META && c < CH_HIGH) begin
                put_char(CH_M);
                put_char(CH_DASH);
                put_char(CH_CARET);
                c = c - CARET_OFS;
            end else if (c == CH_DEL) begin
                put_char(CH_CARET);
                c = CH_QMARK;
            end else if (c < CH_CTL_END && c != CH_NL && c != CH_TAB) begin
                put_char(CH_CARET);
                c = c + CARET_OFS;
            end
        end

        if (opt_show_tabs && c == CH_TAB) begin
            put_char(CH_CARET);
            put_char(CH_I);
        end else begin
            put_char(c);
        end
        // The shown byte, a shown tab included, decides the next line start.
        last_shown = c;

        if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.last_of_run = 1'b1;
            burst.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic void add_option(input logic [CFG_ADDR_W-1:0] addr, input logic val);
        plan.push_back('{ROW_OPTION, addr, val, 8'h00, 1'b0, 1'b0, 4'd0, '0});
    endfunction

    function automatic void add_text(input logic [7:0] b, input logic sof);
        plan.push_back('{ROW_TEXT, '0, 1'b0, b, sof, 1'b0, 4'd0, '0});
    endfunction

    // A row whose shown characters can be read off directly.
    function automatic void add_shown(input logic [7:0] b, input logic sof, input logic [3:0] n,
                                      input logic [8*MAX_OUT-1:0] text);
        plan.push_back('{ROW_TEXT, '0, 1'b0, b, sof, 1'b1, n, text});
    endfunction

    // Mostly line-shaped text: many newlines and tabs, some control and high bytes.
    function automatic logic [7:0] pick_text_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30) begin
            return CH_NL;
        end else if (roll < 40) begin
            return CH_TAB;
        end else if (roll < 80) begin
            return 8'($urandom_range(126, 32));
        end else if (roll < 90) begin
            return ($urandom_range(7) == 0) ? CH_DEL : 8'($urandom_range(31));
        end
        return 8'($urandom_range(255, 128));
    endfunction

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------

    // Stops offering text and waits until every owed character is out, plus
    // a few cycles in case a squeezed line is still in flight.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (shown_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_option(input logic [CFG_ADDR_W-1:0] addr, input logic val);
        pause_until_drained();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_NUMBER_NONBLANK:  opt_number_nonblank = val;
            CFG_NUMBER_ALL:       opt_number_all = val;
            CFG_SHOW_ENDS:        opt_show_ends = val;
            CFG_SQUEEZE_BLANK:    opt_squeeze = val;
            CFG_SHOW_TABS:        opt_show_tabs = val;
            CFG_SHOW_NONPRINTING: opt_nonprinting = val;
            default: ;
        endcase
    endtask

    // Bit order of opts follows the register indexes.
    task automatic load_options(input logic [5:0] opts);
        set_option(CFG_NUMBER_NONBLANK, opts[0]);
        set_option(CFG_NUMBER_ALL, opts[1]);
        set_option(CFG_SHOW_ENDS, opts[2]);
        set_option(CFG_SQUEEZE_BLANK, opts[3]);
        set_option(CFG_SHOW_TABS, opts[4]);
        set_option(CFG_SHOW_NONPRINTING, opts[5]);
        option_sets++;
    endtask

    // Offers one text item, holds it until taken, then books its characters.
    // A typed row replaces the prediction, though the predictor still runs
    // so the line state stays in step.
    task automatic feed(input logic [7:0] b, input logic sof, input logic typed,
                        input logic [3:0] n, input logic [8*MAX_OUT-1:0] text);
        t_in_item item;
        item.data_byte = b;
        item.start_of_file = sof;
        while (!steady && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_shown(b, sof);
        if (typed) begin
            burst.delete();
            for (int i = 0; i < n; i++) begin
                burst.push_back({text[8*(n-1-i) +: 8], i == n - 1});
            end
        end
        foreach (burst[i]) begin
            shown_q.push_back(burst[i]);
        end
        chars_in++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : drive_text
        logic [5:0] opts;
        logic [7:0] b;
        logic       sof;
        int         spin;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= '0;
        i_cfg_wdata <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        opt_number_nonblank = 1'b0;
        opt_number_all = 1'b0;
        opt_show_ends = 1'b0;
        opt_squeeze = 1'b0;
        opt_show_tabs = 1'b0;
        opt_nonprinting = 1'b0;
        line_cnt = '0;
        last_shown = CH_NL;
        blank_run = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain pass-through straight out of reset.
        add_shown("A", 1'b1, 4'd1, "A");
        add_text(8'h00, 1'b0);
        add_text(CH_TAB, 1'b0);
        add_text(CH_NL, 1'b0);

        // Control and high bytes at the edges of each notation range.
        add_option(CFG_SHOW_NONPRINTING, 1'b1);
        add_shown(8'h00, 1'b0, 4'd2, "^@");
        add_shown(8'h1F, 1'b0, 4'd2, "^_");
        add_shown(CH_DEL, 1'b0, 4'd2, "^?");
        add_shown(CH_META, 1'b0, 4'd4, "M-^@");
        add_shown(8'h9F, 1'b0, 4'd4, "M-^_");
        add_text(CH_HIGH, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(CH_NL, 1'b0);
        add_text(CH_TAB, 1'b0);

        // Numbering of every line with end marks. The tab at a line start
        // is shown as a caret pair, and the byte after it is no line start.
        add_option(CFG_SHOW_TABS, 1'b1);
        add_option(CFG_SHOW_ENDS, 1'b1);
        add_option(CFG_NUMBER_ALL, 1'b1);
        add_shown("X", 1'b1, 4'd8, "     1\tX");
        add_shown(CH_NL, 1'b0, 4'd2, "$\n");
        add_shown(CH_TAB, 1'b0, 4'd9, "     2\t^I");
        add_shown("Y", 1'b0, 4'd1, "Y");
        add_shown(CH_NL, 1'b0, 4'd2, "$\n");
        add_shown(CH_NL, 1'b0, 4'd9, "     3\t$\n");

        // Nonblank numbering overrides numbering of all lines; the first empty
        // line keeps a blank number field, the next ones are squeezed away.
        // Writes to the spare indexes must leave every option alone.
        add_option(CFG_NUMBER_NONBLANK, 1'b1);
        add_option(CFG_SQUEEZE_BLANK, 1'b1);
        add_option(CFG_SPARE_LO, 1'b1);
        add_option(CFG_SPARE_HI, 1'b1);
        add_shown(CH_NL, 1'b0, 4'd9, "      \t$\n");
        add_shown(CH_NL, 1'b0, 4'd0, "");
        add_shown(CH_NL, 1'b0, 4'd0, "");
        add_shown("B", 1'b0, 4'd8, "     4\tB");
        add_shown(8'h85, 1'b0, 4'd4, "M-^E");
        // A new file restarts the numbering.
        add_shown("C", 1'b1, 4'd8, "     1\tC");

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_OPTION) begin
                set_option(plan[r].addr, plan[r].val);
            end else begin
                feed(plan[r].data, plan[r].sof, plan[r].typed, plan[r].n_shown,
                     plan[r].shown_text);
            end
        end

        // Random text in phases: every option on, every option off, then
        // random option sets. One phase holds the output off for a long
        // stretch so the filter backs up into its input, one runs without
        // any idling, and one pauses mid-way until the filter has drained.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0) begin
                opts = '1;
            end else if (ph == 1) begin
                opts = '0;
            end else begin
                opts = 6'($urandom);
            end
            load_options(opts);
            steady = (ph == 3);
            for (int k = 0; k < 14; k++) begin
                if (ph == 2 && k == 4) begin
                    hold_req = 1'b1;
                end
                if (ph == 4 && k == 9) begin
                    pause_until_drained();
                end
                b = pick_text_byte();
                if (k == 0) begin
                    sof = 1'($urandom_range(1));
                end else begin
                    sof = ($urandom_range(99) < 3);
                end
                feed(b, sof, 1'b0, 4'd0, '0);
            end
        end
        steady = 1'b0;

        // Wind down: let the last burst out, then a few quiet cycles.
        i_in_valid <= 1'b0;
        for (spin = 0; spin < 5000 && shown_q.size() != 0; spin++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (shown_q.size() != 0) begin
            $display("%0d expected characters never came out", shown_q.size());
            bad_count += shown_q.size();
        end

        $display("Filtered %0d text items into %0d shown characters under %0d option sets,",
                 chars_in, chars_out, option_sets + 1);
        $display("with a long output hold-off, a drain pause and a stretch without idling.");
        if (bad_count == 0) begin
            $display("PASS text_stream_visualize_filter");
        end else begin
            $display("FAIL text_stream_visualize_filter");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial begin : drive_ready
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!steady && $urandom_range(99) < 13) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check: each taken character against the oldest one owed.
    // ------------------------------------------------------------------
    task automatic report_fault(input string what, input t_out_item want, input t_out_item got);
        if (bad_count < 10) begin
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, want.out_byte, want.last_of_run,
                     got.out_byte, got.last_of_run);
        end
        bad_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chars_out++;
            if (shown_q.size() == 0) begin
                report_fault("character with none owed", '0, o_out_item);
            end else begin
                want = shown_q.pop_front();
                if (o_out_item.out_byte !== want.out_byte) begin
                    report_fault("wrong shown byte", want, o_out_item);
                end
                if (o_out_item.last_of_run !== want.last_of_run) begin
                    report_fault("wrong end-of-burst flag", want, o_out_item);
                end
            end
        end
    end

endmodule
